### rtl/clq_pkg.sv
// ----------------------------------------------------------------------------
// clq_pkg
// Shared types and constants of the circular list queue manager.
// ----------------------------------------------------------------------------
`default_nettype none

package clq_pkg;

  localparam int NUM_ELEMS_DEF  = 64;
  localparam int NUM_QUEUES_DEF = 4;

  localparam int REQ_W    = 2;
  localparam int STATUS_W = 3;

  // request codes, code 3 acts as a query
  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_QUERY  = 2'd2
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_LINKED   = 3'd2,
    ST_UNLINKED = 3'd3,
    ST_OTHER    = 3'd4
  } status_t;

  // write enables of the element memories
  typedef struct packed {
    logic nxt;
    logic prv;
    logic lnk;
    logic own;
  } elem_we_t;

  // write enables of the queue memories
  typedef struct packed {
    logic head;
    logic cnt;
  } queue_we_t;

endpackage

`default_nettype wire

### rtl/circular_list_queue_manager.sv
// Sequence: query, remove and append to an empty queue pass S_RD1 and S_RESP
// before the output register; append to a non-empty queue also passes S_AP2
// and S_AP3, as it needs a second link read and two link writes on the element memories.
// A new beat is taken only once the last one has left S_RESP; in_tready is high only while idle.
// Reset: synchronous active-low rst_n, followed by a clearing pass over every
// element and queue slot with in_tready low.
// ----------------------------------------------------------------------------
// circular_list_queue_manager
// Circular doubly linked queues over a shared pool of element slots, with
// an output register on the result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_list_queue_manager #(
  parameter int NUM_ELEMS  = clq_pkg::NUM_ELEMS_DEF,
  parameter int NUM_QUEUES = clq_pkg::NUM_QUEUES_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  // req_type, queue_id, elem_id, zero pad
  input  wire logic [((clq_pkg::REQ_W + ((NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1)
                       + $clog2(NUM_ELEMS) + 7) / 8) * 8 - 1:0] in_tdata,
  output logic      out_tvalid,
  input  wire logic out_tready,
  // status, fill_count, head_elem, head_valid, zero pad
  output logic [((clq_pkg::STATUS_W + $clog2(NUM_ELEMS + 1) + $clog2(NUM_ELEMS)
                  + 1 + 7) / 8) * 8 - 1:0] out_tdata
);

  localparam int EW    = $clog2(NUM_ELEMS);
  localparam int QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int CW    = $clog2(NUM_ELEMS + 1);
  localparam int RW    = clq_pkg::REQ_W;
  localparam int IN_F  = RW + QW + EW;
  localparam int OUT_F = clq_pkg::STATUS_W + CW + EW + 1;
  localparam int OUT_W = ((OUT_F + 7) / 8) * 8;

  logic [RW-1:0] in_req;
  logic [QW-1:0] in_q;
  logic [EW-1:0] in_e;

  assign in_req = in_tdata[RW-1:0];
  assign in_q   = in_tdata[RW+QW-1:RW];
  assign in_e   = in_tdata[IN_F-1:RW+QW];

  clq_pkg::elem_we_t  e_we;
  clq_pkg::queue_we_t q_we;
  logic [EW-1:0] nxt_wa, nxt_wd, prv_wa, prv_wd, lnk_wa, e_rd_addr;
  logic          lnk_wd;
  logic [QW-1:0] own_wd;
  logic [EW-1:0] nxt_rd, prv_rd;
  logic          lnk_rd;
  logic [QW-1:0] own_rd;
  logic [QW-1:0] q_wa, q_rd_addr;
  logic [EW-1:0] head_wd, head_rd;
  logic [CW-1:0] cnt_wd, cnt_rd;

  logic             res_valid, res_ready, res_hv;
  clq_pkg::status_t res_status;
  logic [CW-1:0]    res_size;
  logic [EW-1:0]    res_head;

  logic             out_valid_r;
  logic [OUT_W-1:0] out_data_r;

  clq_elem_store #(
    .NUM_ELEMS  (NUM_ELEMS),
    .NUM_QUEUES (NUM_QUEUES)
  ) u_elem (
    .clk     (clk),
    .we      (e_we),
    .nxt_wa  (nxt_wa),
    .nxt_wd  (nxt_wd),
    .prv_wa  (prv_wa),
    .prv_wd  (prv_wd),
    .lnk_wa  (lnk_wa),
    .lnk_wd  (lnk_wd),
    .own_wd  (own_wd),
    .rd_addr (e_rd_addr),
    .nxt_rd  (nxt_rd),
    .prv_rd  (prv_rd),
    .lnk_rd  (lnk_rd),
    .own_rd  (own_rd)
  );

  clq_queue_store #(
    .NUM_ELEMS  (NUM_ELEMS),
    .NUM_QUEUES (NUM_QUEUES)
  ) u_queue (
    .clk     (clk),
    .we      (q_we),
    .wa      (q_wa),
    .head_wd (head_wd),
    .cnt_wd  (cnt_wd),
    .rd_addr (q_rd_addr),
    .head_rd (head_rd),
    .cnt_rd  (cnt_rd)
  );

  clq_ctrl #(
    .NUM_ELEMS  (NUM_ELEMS),
    .NUM_QUEUES (NUM_QUEUES)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_req     (in_req),
    .in_q       (in_q),
    .in_e       (in_e),
    .e_we       (e_we),
    .nxt_wa     (nxt_wa),
    .nxt_wd     (nxt_wd),
    .prv_wa     (prv_wa),
    .prv_wd     (prv_wd),
    .lnk_wa     (lnk_wa),
    .lnk_wd     (lnk_wd),
    .own_wd     (own_wd),
    .e_rd_addr  (e_rd_addr),
    .nxt_rd     (nxt_rd),
    .prv_rd     (prv_rd),
    .lnk_rd     (lnk_rd),
    .own_rd     (own_rd),
    .q_we       (q_we),
    .q_wa       (q_wa),
    .head_wd    (head_wd),
    .cnt_wd     (cnt_wd),
    .q_rd_addr  (q_rd_addr),
    .head_rd    (head_rd),
    .cnt_rd     (cnt_rd),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_status (res_status),
    .res_size   (res_size),
    .res_head   (res_head),
    .res_hv     (res_hv)
  );

  // output register frees the sequencer while a beat waits downstream
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= OUT_W'({res_hv, res_head, res_size, res_status});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

### rtl/clq_elem_store.sv
// ----------------------------------------------------------------------------
// clq_elem_store
// Per element memories: next and prev links, linked flag and owner queue.
// ----------------------------------------------------------------------------
`default_nettype none

module clq_elem_store #(
  parameter int NUM_ELEMS  = clq_pkg::NUM_ELEMS_DEF,
  parameter int NUM_QUEUES = clq_pkg::NUM_QUEUES_DEF
) (
  input  wire logic                      clk,
  input  wire clq_pkg::elem_we_t         we,
  input  wire logic [$clog2(NUM_ELEMS)-1:0] nxt_wa,
  input  wire logic [$clog2(NUM_ELEMS)-1:0] nxt_wd,
  input  wire logic [$clog2(NUM_ELEMS)-1:0] prv_wa,
  input  wire logic [$clog2(NUM_ELEMS)-1:0] prv_wd,
  input  wire logic [$clog2(NUM_ELEMS)-1:0] lnk_wa,
  input  wire logic                      lnk_wd,
  input  wire logic [((NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1)-1:0] own_wd,
  input  wire logic [$clog2(NUM_ELEMS)-1:0] rd_addr,
  output logic [$clog2(NUM_ELEMS)-1:0]   nxt_rd,
  output logic [$clog2(NUM_ELEMS)-1:0]   prv_rd,
  output logic                           lnk_rd,
  output logic [((NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1)-1:0] own_rd
);

  localparam int EW = $clog2(NUM_ELEMS);
  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

  logic [EW-1:0] nxt_mem [NUM_ELEMS];
  logic [EW-1:0] prv_mem [NUM_ELEMS];
  logic          lnk_mem [NUM_ELEMS];
  logic [QW-1:0] own_mem [NUM_ELEMS];

  always_ff @(posedge clk) begin
    if (we.nxt) begin
      nxt_mem[nxt_wa] <= nxt_wd;
    end
    if (we.prv) begin
      prv_mem[prv_wa] <= prv_wd;
    end
    if (we.lnk) begin
      lnk_mem[lnk_wa] <= lnk_wd;
    end
    if (we.own) begin
      own_mem[lnk_wa] <= own_wd;
    end
    nxt_rd <= nxt_mem[rd_addr];
    prv_rd <= prv_mem[rd_addr];
    lnk_rd <= lnk_mem[rd_addr];
    own_rd <= own_mem[rd_addr];
  end

endmodule

`default_nettype wire

### rtl/clq_queue_store.sv
// ----------------------------------------------------------------------------
// clq_queue_store
// Per queue memories: head element and element count.
// ----------------------------------------------------------------------------
`default_nettype none

module clq_queue_store #(
  parameter int NUM_ELEMS  = clq_pkg::NUM_ELEMS_DEF,
  parameter int NUM_QUEUES = clq_pkg::NUM_QUEUES_DEF
) (
  input  wire logic                          clk,
  input  wire clq_pkg::queue_we_t            we,
  input  wire logic [((NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1)-1:0] wa,
  input  wire logic [$clog2(NUM_ELEMS)-1:0]  head_wd,
  input  wire logic [$clog2(NUM_ELEMS+1)-1:0] cnt_wd,
  input  wire logic [((NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1)-1:0] rd_addr,
  output logic [$clog2(NUM_ELEMS)-1:0]       head_rd,
  output logic [$clog2(NUM_ELEMS+1)-1:0]     cnt_rd
);

  localparam int EW = $clog2(NUM_ELEMS);
  localparam int CW = $clog2(NUM_ELEMS + 1);

  logic [EW-1:0] head_mem [NUM_QUEUES];
  logic [CW-1:0] cnt_mem  [NUM_QUEUES];

  always_ff @(posedge clk) begin
    if (we.head) begin
      head_mem[wa] <= head_wd;
    end
    if (we.cnt) begin
      cnt_mem[wa] <= cnt_wd;
    end
    head_rd <= head_mem[rd_addr];
    cnt_rd  <= cnt_mem[rd_addr];
  end

endmodule

`default_nettype wire

### rtl/clq_ctrl.sv
// ----------------------------------------------------------------------------
// clq_ctrl
// Request sequencer: clearing sweep, membership checks, link updates and the
// shared count adder.
// ----------------------------------------------------------------------------
`default_nettype none

module clq_ctrl #(
  parameter int NUM_ELEMS  = clq_pkg::NUM_ELEMS_DEF,
  parameter int NUM_QUEUES = clq_pkg::NUM_QUEUES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // request side
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [clq_pkg::REQ_W-1:0]     in_req,
  input  wire logic [((NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1)-1:0] in_q,
  input  wire logic [$clog2(NUM_ELEMS)-1:0]  in_e,
  // element store
  output clq_pkg::elem_we_t                  e_we,
  output logic [$clog2(NUM_ELEMS)-1:0]       nxt_wa,
  output logic [$clog2(NUM_ELEMS)-1:0]       nxt_wd,
  output logic [$clog2(NUM_ELEMS)-1:0]       prv_wa,
  output logic [$clog2(NUM_ELEMS)-1:0]       prv_wd,
  output logic [$clog2(NUM_ELEMS)-1:0]       lnk_wa,
  output logic                               lnk_wd,
  output logic [((NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1)-1:0] own_wd,
  output logic [$clog2(NUM_ELEMS)-1:0]       e_rd_addr,
  input  wire logic [$clog2(NUM_ELEMS)-1:0]  nxt_rd,
  input  wire logic [$clog2(NUM_ELEMS)-1:0]  prv_rd,
  input  wire logic                          lnk_rd,
  input  wire logic [((NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1)-1:0] own_rd,
  // queue store
  output clq_pkg::queue_we_t                 q_we,
  output logic [((NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1)-1:0] q_wa,
  output logic [$clog2(NUM_ELEMS)-1:0]       head_wd,
  output logic [$clog2(NUM_ELEMS+1)-1:0]     cnt_wd,
  output logic [((NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1)-1:0] q_rd_addr,
  input  wire logic [$clog2(NUM_ELEMS)-1:0]  head_rd,
  input  wire logic [$clog2(NUM_ELEMS+1)-1:0] cnt_rd,
  // result side
  output logic                               res_valid,
  input  wire logic                          res_ready,
  output clq_pkg::status_t                   res_status,
  output logic [$clog2(NUM_ELEMS+1)-1:0]     res_size,
  output logic [$clog2(NUM_ELEMS)-1:0]       res_head,
  output logic                               res_hv
);

  localparam int EW    = $clog2(NUM_ELEMS);
  localparam int QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int CW    = $clog2(NUM_ELEMS + 1);
  localparam int CLR_N = (NUM_ELEMS > NUM_QUEUES) ? NUM_ELEMS : NUM_QUEUES;
  localparam int CLRW  = $clog2(CLR_N);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_RD1   = 6'b000100,
    S_AP2   = 6'b001000,
    S_AP3   = 6'b010000,
    S_RESP  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [CLRW-1:0]           clr_r, clr_nxt;
  logic [clq_pkg::REQ_W-1:0] req_r;
  logic [QW-1:0]             q_r;
  logic [EW-1:0]             e_r;
  logic                      q_oor_r;
  logic                      e_oor_r;
  logic [EW-1:0]             first_r, first_nxt;
  logic [EW-1:0]             last_r, last_nxt;

  clq_pkg::status_t          st_r, st_nxt;
  logic [CW-1:0]             size_r, size_nxt;
  logic [EW-1:0]             rhead_r, rhead_nxt;
  logic                      hv_r, hv_nxt;

  // shared count adder: +1 for append, -1 for remove
  logic [CW-1:0] cnt_delta;
  logic [CW-1:0] cnt_sum;
  logic          is_remove;

  assign is_remove = (req_r == clq_pkg::REQ_REMOVE);
  assign cnt_delta = is_remove ? {CW{1'b1}} : CW'(1);
  assign cnt_sum   = cnt_rd + cnt_delta;

  assign in_ready   = (state_r == S_IDLE);
  assign res_valid  = (state_r == S_RESP);
  assign res_status = st_r;
  assign res_size   = size_r;
  assign res_head   = rhead_r;
  assign res_hv     = hv_r;

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    first_nxt = first_r;
    last_nxt  = last_r;
    st_nxt    = st_r;
    size_nxt  = size_r;
    rhead_nxt = rhead_r;
    hv_nxt    = hv_r;

    e_we      = '0;
    nxt_wa    = e_r;
    nxt_wd    = e_r;
    prv_wa    = e_r;
    prv_wd    = e_r;
    lnk_wa    = e_r;
    lnk_wd    = 1'b0;
    own_wd    = q_r;
    e_rd_addr = e_r;

    q_we      = '0;
    q_wa      = q_r;
    head_wd   = e_r;
    cnt_wd    = cnt_sum;
    q_rd_addr = q_r;

    unique case (state_r)
      S_CLEAR: begin
        lnk_wa   = clr_r[EW-1:0];
        q_wa     = clr_r[QW-1:0];
        cnt_wd   = '0;
        e_we.lnk = (32'(clr_r) < NUM_ELEMS);
        q_we.cnt = (32'(clr_r) < NUM_QUEUES);
        clr_nxt  = clr_r + CLRW'(1);
        if (32'(clr_r) == CLR_N - 1) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        e_rd_addr = in_e;
        q_rd_addr = in_q;
        if (in_valid) begin
          state_nxt = S_RD1;
        end
      end

      S_RD1: begin
        // error default: report the queue as it stands
        size_nxt  = cnt_rd;
        hv_nxt    = (cnt_rd != '0);
        rhead_nxt = (cnt_rd != '0) ? head_rd : '0;
        st_nxt    = clq_pkg::ST_OK;
        state_nxt = S_RESP;
        e_rd_addr = head_rd;
        if (q_oor_r) begin
          st_nxt    = clq_pkg::ST_EMPTY;
          size_nxt  = '0;
          hv_nxt    = 1'b0;
          rhead_nxt = '0;
        end else if (req_r == clq_pkg::REQ_APPEND) begin
          if (e_oor_r) begin
            st_nxt = clq_pkg::ST_UNLINKED;
          end else if (lnk_rd) begin
            st_nxt = clq_pkg::ST_LINKED;
          end else if (cnt_rd == '0) begin
            // first element forms a ring of one
            e_we      = '{nxt: 1'b1, prv: 1'b1, lnk: 1'b1, own: 1'b1};
            lnk_wd    = 1'b1;
            q_we      = '{head: 1'b1, cnt: 1'b1};
            size_nxt  = cnt_sum;
            hv_nxt    = 1'b1;
            rhead_nxt = e_r;
          end else begin
            first_nxt = head_rd;
            size_nxt  = cnt_sum;
            state_nxt = S_AP2;
          end
        end else if (req_r == clq_pkg::REQ_REMOVE) begin
          if (cnt_rd == '0) begin
            st_nxt = clq_pkg::ST_EMPTY;
          end else if (e_oor_r || !lnk_rd) begin
            st_nxt = clq_pkg::ST_UNLINKED;
          end else if (own_rd != q_r) begin
            st_nxt = clq_pkg::ST_OTHER;
          end else begin
            e_we.lnk = 1'b1;
            q_we.cnt = 1'b1;
            size_nxt = cnt_sum;
            if (cnt_rd == CW'(1)) begin
              hv_nxt    = 1'b0;
              rhead_nxt = '0;
            end else begin
              // unlink from the ring
              e_we.nxt = 1'b1;
              e_we.prv = 1'b1;
              nxt_wa   = prv_rd;
              nxt_wd   = nxt_rd;
              prv_wa   = nxt_rd;
              prv_wd   = prv_rd;
              if (head_rd == e_r) begin
                q_we.head = 1'b1;
                head_wd   = nxt_rd;
                rhead_nxt = nxt_rd;
              end
            end
          end
        end
      end

      S_AP2: begin
        // prv_rd now holds the tail of the ring
        last_nxt  = prv_rd;
        e_we      = '{nxt: 1'b1, prv: 1'b1, lnk: 1'b1, own: 1'b1};
        lnk_wd    = 1'b1;
        prv_wa    = first_r;
        prv_wd    = e_r;
        nxt_wa    = e_r;
        nxt_wd    = first_r;
        q_we.cnt  = 1'b1;
        rhead_nxt = first_r;
        hv_nxt    = 1'b1;
        state_nxt = S_AP3;
      end

      S_AP3: begin
        e_we.nxt  = 1'b1;
        e_we.prv  = 1'b1;
        nxt_wa    = last_r;
        nxt_wd    = e_r;
        prv_wa    = e_r;
        prv_wd    = last_r;
        state_nxt = S_RESP;
      end

      S_RESP: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      req_r   <= in_req;
      q_r     <= in_q;
      e_r     <= in_e;
      q_oor_r <= (32'(in_q) >= NUM_QUEUES);
      e_oor_r <= (32'(in_e) >= NUM_ELEMS);
    end
    first_r <= first_nxt;
    last_r  <= last_nxt;
    st_r    <= st_nxt;
    size_r  <= size_nxt;
    rhead_r <= rhead_nxt;
    hv_r    <= hv_nxt;
  end

endmodule

`default_nettype wire
